[sv/sopc_pkg.sv]
// Package for the segmented odd-prime counter: sequencer states, widths, config indexes.
// No dependencies.
`timescale 1ns / 1ps
package sopc_pkg;
  localparam int CountW = 24;
  localparam int LimitW = 24;
  localparam int SegLenW = 13;
  localparam int NumberBits = 24;

  // configuration register indexes
  localparam logic CfgLimit = 1'b0;
  localparam logic CfgSegLen = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_SQRT, ST_BCLR, ST_BSCAN, ST_BRD, ST_BMARK,
    ST_SEGINIT, ST_SCLR, ST_PSCAN, ST_PRD, ST_PSQ, ST_PMOD, ST_PFIRST,
    ST_SMARK, ST_COUNT, ST_CRD, ST_NEXTSEG, ST_DONE
  } state_e;
endpackage

[sv/sopc_divider.sv]
// Restoring divider: remainder of a by b, one quotient bit per cycle.
// Depends on nothing else.
`timescale 1ns / 1ps
module sopc_divider #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [DenW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] num_q, num_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[DenW-1:0], num_q[NumW-1]};
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0;
      cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      rem_d = (trial >= {1'b0, den_q}) ? trial - {1'b0, den_q} : trial;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[DenW-1:0];
endmodule

[sv/segmented_odd_prime_counter.sv]
// Top level: segmented sieve sequencer with base/segment bitmaps and a divider.
// Depends on sopc_pkg and sopc_divider.
//
// channel  dir  fields (lsb up)
// s_axis   in   tdata: range_low[23:0], range_high[47:24]
// m_axis   out  tdata: prime_count[23:0], range_error[24], pad
// cfg      in   0 limit, 1 segment_length
//
// One request at a time; each segment is cleared, the base entries are scanned,
// a prime whose square does not exceed the segment start takes the modulo path
// (divider), each crossed-out entry is written, and the segment is counted.
// Base sieve: square root, clear, scan, marks. Bitmaps need no clear after reset.
// Input is taken while a result waits; the next result holds in DONE until
// m_axis_tready empties the result register.
`timescale 1ns / 1ps
module segmented_odd_prime_counter #(
  parameter int unsigned SEGMENT_DEPTH = 4096,
  parameter int unsigned BASE_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // range_low, range_high
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // prime_count, range_error
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);
  import sopc_pkg::*;
  localparam int unsigned SW = $clog2(SEGMENT_DEPTH);
  localparam int unsigned BW = $clog2(BASE_DEPTH);
  localparam int unsigned NW = NumberBits + 2;
  localparam int unsigned PW = BW + 2;  // prime width
  localparam int unsigned WW = 2 * PW + 2;

  logic [LimitW-1:0] limit_q;
  logic [SegLenW-1:0] seglen_q;
  state_e state_q, state_d;

  logic [NW-1:0] lo_q, hi_q, s_q, top_q, root_q, wide_a;
  logic [NW-1:0] root_fin, half_root;
  logic [WW-1:0] sq_q, bstart;
  logic [BW:0]  bsize_q, bi_q, bm_q, bsize_nx;
  logic [SW:0]  size_q, k_q, len_q;
  logic [PW-1:0] p_q;
  logic [4:0]   bit_q;
  logic [CountW-1:0] cnt_q;
  logic         err_q;
  logic [31:0]  out_q;
  logic         ov_q;

  logic base_mem [BASE_DEPTH];
  logic seg_mem  [SEGMENT_DEPTH];
  logic base_rd_q, seg_rd_q;
  logic         b_we, s_we;
  logic [BW-1:0] b_addr;
  logic [SW-1:0] s_addr;
  logic         b_wv;

  logic div_start, div_done;
  logic [PW-1:0] div_rem;
  logic [NW-1:0] lo_in, hi_in, lo_r, hi_r;

  assign lo_in = NW'(s_axis_tdata[NumberBits-1:0]);
  assign hi_in = NW'(s_axis_tdata[2*NumberBits-1:NumberBits]);
  always_comb begin
    lo_r = (lo_in < NW'(3)) ? NW'(3) : lo_in;
    if (!lo_r[0]) lo_r = lo_r + 1'b1;
    hi_r = (hi_in[0] || hi_in == '0) ? hi_in : hi_in - 1'b1;
  end

  sopc_divider #(.NumW(NW), .DenW(PW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(s_q), .den_i(p_q),
    .done_o(div_done), .rem_o(div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (b_we) base_mem[b_addr] <= b_wv;
    base_rd_q <= base_mem[b_addr];
    if (s_we) seg_mem[s_addr] <= 1'b1 & !(state_q == ST_SCLR);
    seg_rd_q <= seg_mem[s_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitW'(1000000); seglen_q <= SegLenW'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLimit:  limit_q <= cfg_wdata_i;
        CfgSegLen: seglen_q <= cfg_wdata_i[SegLenW-1:0];
      endcase
    end
  end

  // root after the last trial bit, and the base bitmap size it gives
  assign wide_a = root_q | (NW'(1) << bit_q);
  always_comb begin
    root_fin = ((wide_a * wide_a) <= (2*NW)'(limit_q)) ? wide_a : root_q;
    half_root = (root_fin - NW'(3)) >> 1;
    if (root_fin < NW'(3)) bsize_nx = '0;
    else if (half_root >= NW'(BASE_DEPTH)) bsize_nx = (BW+1)'(BASE_DEPTH);
    else bsize_nx = (BW+1)'(half_root + NW'(1));
  end

  // first base index crossed out by p, (p*p - 3) / 2
  assign bstart = (sq_q - WW'(3)) >> 1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_axis_tvalid && s_axis_tready) state_d = ST_CHECK;
      ST_CHECK:   state_d = err_q ? ST_DONE : ST_SQRT;
      ST_SQRT:    if (bit_q == 5'd0) state_d = (bsize_nx == '0) ? ST_SEGINIT : ST_BCLR;
      ST_BCLR:    if (bi_q + 1'b1 == bsize_q) state_d = ST_BSCAN;
      ST_BSCAN:   state_d = (bi_q >= bsize_q) ? ST_SEGINIT : ST_BRD;
      ST_BRD:     state_d = base_rd_q ? ST_BSCAN :
                            (sq_q > WW'(limit_q)) ? ST_SEGINIT :
                            (bstart < WW'(bsize_q) ? ST_BMARK : ST_BSCAN);
      ST_BMARK:   if (bm_q + PW'(p_q) >= bsize_q) state_d = ST_BSCAN;
      ST_SEGINIT: state_d = (s_q > hi_q) ? ST_DONE : ST_SCLR;
      ST_SCLR:    if (k_q + 1'b1 == size_q) state_d = ST_PSCAN;
      ST_PSCAN:   state_d = (bi_q >= bsize_q) ? ST_COUNT : ST_PRD;
      ST_PRD:     state_d = base_rd_q ? ST_PSCAN : ST_PSQ;
      ST_PSQ:     state_d = (WW'(sq_q) > WW'(top_q)) ? ST_COUNT :
                            (WW'(sq_q) > WW'(s_q) ? ST_SMARK : ST_PMOD);
      ST_PMOD:    if (div_done) state_d = ST_PFIRST;
      ST_PFIRST:  state_d = ST_SMARK;
      ST_SMARK:   if (k_q >= size_q || k_q + (SW+1)'(p_q) >= size_q) state_d = ST_PSCAN;
      ST_COUNT:   state_d = ST_CRD;
      ST_CRD:     if (k_q >= size_q) state_d = ST_NEXTSEG;
      ST_NEXTSEG: state_d = ST_SEGINIT;
      ST_DONE:    if (!ov_q) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    b_we = 1'b0; b_wv = 1'b0; b_addr = bi_q[BW-1:0];
    s_we = 1'b0; s_addr = k_q[SW-1:0];
    div_start = 1'b0;
    unique case (state_q)
      ST_BCLR:  b_we = 1'b1;
      ST_BMARK: begin b_we = 1'b1; b_wv = 1'b1; b_addr = bm_q[BW-1:0]; end
      ST_SCLR:  s_we = 1'b1;
      ST_SMARK: s_we = (k_q < size_q);
      ST_PSQ:   div_start = !(WW'(sq_q) > WW'(top_q)) && !(WW'(sq_q) > WW'(s_q));
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ov_q <= 1'b0; cnt_q <= '0; err_q <= 1'b0;
      p_q <= PW'(3); s_q <= '0;
    end else begin
      state_q <= state_d;
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          lo_q <= lo_r; hi_q <= hi_r;
          err_q <= (hi_r < NW'(3)) || (lo_r > hi_r) || (hi_in > NW'(limit_q));
          root_q <= '0; bit_q <= 5'(NumberBits / 2); cnt_q <= '0;
          len_q <= (seglen_q == '0) ? (SW+1)'(1) :
                   ((32'(seglen_q) > SEGMENT_DEPTH) ? (SW+1)'(SEGMENT_DEPTH)
                                                   : (SW+1)'(seglen_q));
        end
        ST_CHECK: s_q <= lo_q;
        ST_SQRT: begin
          root_q <= root_fin;
          if (bit_q == 5'd0) begin
            bsize_q <= bsize_nx; bi_q <= '0;
          end else bit_q <= bit_q - 1'b1;
        end
        default: ;
      endcase
      if (state_q == ST_BCLR) bi_q <= (bi_q + 1'b1 == bsize_q) ? '0 : bi_q + 1'b1;
      if (state_q == ST_BSCAN) begin
        p_q <= PW'({bi_q, 1'b1}) + PW'(2);
      end
      if (state_q == ST_BSCAN) sq_q <= WW'((PW'({bi_q,1'b1}) + PW'(2))) *
                                        WW'((PW'({bi_q,1'b1}) + PW'(2)));
      if (state_q == ST_BRD) begin
        bi_q <= bi_q + 1'b1;
        bm_q <= (BW+1)'(bstart);
      end
      if (state_q == ST_BMARK) bm_q <= bm_q + (BW+1)'(p_q);
      if (state_q == ST_SEGINIT) begin
        top_q <= (s_q + NW'({len_q, 1'b0}) - 2 > hi_q) ? hi_q
                 : s_q + NW'({len_q, 1'b0}) - 2;
        size_q <= (SW+1)'((((s_q + NW'({len_q,1'b0}) - 2 > hi_q) ? hi_q
                 : s_q + NW'({len_q,1'b0}) - 2) - s_q) >> 1) + 1'b1;
        k_q <= '0; bi_q <= '0;
      end
      if (state_q == ST_SCLR) k_q <= k_q + 1'b1;
      if (state_q == ST_PSCAN) begin
        p_q <= PW'({bi_q, 1'b1}) + PW'(2);
        sq_q <= WW'((PW'({bi_q,1'b1}) + PW'(2))) * WW'((PW'({bi_q,1'b1}) + PW'(2)));
      end
      if (state_q == ST_PRD) bi_q <= bi_q + 1'b1;
      if (state_q == ST_PSQ) k_q <= (SW+1)'((sq_q - WW'(s_q)) >> 1);
      if (state_q == ST_PFIRST) begin
        if (div_rem == '0) k_q <= '0;
        else if (!div_rem[0]) k_q <= (SW+1)'(p_q - (div_rem >> 1));
        else k_q <= (SW+1)'((p_q - div_rem) >> 1);
      end
      if (state_q == ST_SMARK) k_q <= k_q + (SW+1)'(p_q);
      if (state_q == ST_COUNT) k_q <= '0;
      if (state_q == ST_CRD) begin
        if (k_q != '0 && k_q <= size_q && !seg_rd_q) cnt_q <= cnt_q + 1'b1;
        if (k_q < size_q) k_q <= k_q + 1'b1;
        else k_q <= size_q + 1'b1;
      end
      if (state_q == ST_NEXTSEG) s_q <= s_q + NW'({len_q, 1'b0});
      if (state_q == ST_DONE && !ov_q) begin
        ov_q <= 1'b1;
        out_q <= {7'd0, err_q, err_q ? CountW'(0) : cnt_q};
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[23:0] == '0)
    else $error("error with count");
endmodule
